[hw/rtl/lcmq_pkg.sv]
`timescale 1ns / 1ps

package lcmq_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_SETS_DEF    = 64;
    localparam int MAX_WAYS_DEF    = 8;
    localparam int QUEUE_SLOTS_DEF = 20;

    // Fixed field widths.
    localparam int ADDR_W   = 64;
    localparam int STAMP_W  = 64;
    localparam int CNT_W    = 32;
    localparam int REQ_W    = 2;
    localparam int SIB_W    = 3;
    localparam int WAYS_W   = 4;
    localparam int OFS_W    = 4;
    localparam int SETRAW_W = 7;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_SINGLE = 2'd0,
        REQ_MODIFY = 2'd1,
        REQ_DRAIN  = 2'd2
    } t_req;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_SET_INDEX_BITS = 2'd0,
        REG_WAYS_IN_USE    = 2'd1,
        REG_OFFSET_BITS    = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC,
        S_PRB_RD,
        S_PRB_CMP,
        S_RESOLVE,
        S_COMMIT,
        S_QS,
        S_QDEC,
        S_DRN_INIT,
        S_DRN_LOAD,
        S_DRN_NEXT,
        S_DRN_RET,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic clear_step;
        logic lk_from_acc;
        logic lk_from_queue;
        logic probe_init;
        logic probe_rd;
        logic probe_cmp;
        logic commit;
        logic drain_mode;
        logic q_zero;
        logic q_inc;
        logic q_merge;
        logic q_new;
        logic q_clear;
        logic drain_start;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic hit_now;
        logic probe_last;
        logic hit_found;
        logic q_at_end;
        logic q_match;
        logic can_merge;
        logic can_new;
        logic q_empty;
        logic q_last;
    } t_dp_sts;

endpackage

[hw/rtl/lcmq_ram.sv]
`timescale 1ns / 1ps

module lcmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[hw/rtl/lcmq_ctrl.sv]
`timescale 1ns / 1ps

module lcmq_ctrl import lcmq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [REQ_W-1:0] i_req_type,
    input  t_dp_sts          i_sts,
    output t_dp_cmd          o_cmd,
    output logic             busy,
    output logic             o_valid
);

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_retry, n_retry;
    logic   r_mode, n_mode;

    // State and flag registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_second <= 1'b0;
            r_retry  <= 1'b0;
            r_mode   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_retry  <= n_retry;
            r_mode   <= n_mode;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    // Next state and datapath commands.
    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        n_retry  = r_retry;
        n_mode   = r_mode;
        o_cmd    = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    case (i_req_type)
                        REQ_SINGLE: begin
                            n_second = 1'b0;
                            n_state  = S_ACC;
                        end
                        REQ_MODIFY: begin
                            n_second = 1'b1;
                            n_state  = S_ACC;
                        end
                        REQ_DRAIN: begin
                            n_retry = 1'b0;
                            n_state = S_DRN_INIT;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_ACC: begin
                o_cmd.lk_from_acc = 1'b1;
                o_cmd.probe_init  = 1'b1;
                n_state           = S_PRB_RD;
            end
            S_PRB_RD: begin
                o_cmd.probe_rd = 1'b1;
                n_state        = S_PRB_CMP;
            end
            S_PRB_CMP: begin
                o_cmd.probe_cmp = 1'b1;
                if (i_sts.hit_now || i_sts.probe_last) begin
                    n_state = S_RESOLVE;
                end else begin
                    n_state = S_PRB_RD;
                end
            end
            S_RESOLVE: begin
                if (r_mode || i_sts.hit_found) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.q_zero = 1'b1;
                    n_state      = S_QS;
                end
            end
            S_COMMIT: begin
                o_cmd.commit     = 1'b1;
                o_cmd.drain_mode = r_mode;
                if (r_mode) begin
                    n_state = S_DRN_NEXT;
                end else begin
                    n_state  = r_second ? S_ACC : S_DONE;
                    n_second = 1'b0;
                end
            end
            S_QS: begin
                if (i_sts.q_match || i_sts.q_at_end) begin
                    n_state = S_QDEC;
                end else begin
                    o_cmd.q_inc = 1'b1;
                end
            end
            S_QDEC: begin
                if (i_sts.q_match && i_sts.can_merge) begin
                    o_cmd.q_merge = 1'b1;
                    n_state       = r_second ? S_ACC : S_DONE;
                    n_second      = 1'b0;
                end else if (!i_sts.q_match && i_sts.can_new) begin
                    o_cmd.q_new = 1'b1;
                    n_state     = r_second ? S_ACC : S_DONE;
                    n_second    = 1'b0;
                end else begin
                    // No room: replay the queue, then look the access up again.
                    n_retry = 1'b1;
                    n_state = S_DRN_INIT;
                end
            end
            S_DRN_INIT: begin
                if (i_sts.q_empty) begin
                    n_state = S_DRN_RET;
                end else begin
                    o_cmd.drain_start = 1'b1;
                    o_cmd.q_zero      = 1'b1;
                    n_mode            = 1'b1;
                    n_state           = S_DRN_LOAD;
                end
            end
            S_DRN_LOAD: begin
                o_cmd.lk_from_queue = 1'b1;
                o_cmd.probe_init    = 1'b1;
                n_state             = S_PRB_RD;
            end
            S_DRN_NEXT: begin
                if (i_sts.q_last) begin
                    o_cmd.q_clear = 1'b1;
                    n_state       = S_DRN_RET;
                end else begin
                    o_cmd.q_inc = 1'b1;
                    n_state     = S_DRN_LOAD;
                end
            end
            S_DRN_RET: begin
                n_mode = 1'b0;
                if (r_retry) begin
                    n_retry = 1'b0;
                    n_state = S_ACC;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/lcmq_dp.sv]
`timescale 1ns / 1ps

module lcmq_dp import lcmq_pkg::*; #(
    parameter int MAX_SETS    = MAX_SETS_DEF,
    parameter int MAX_WAYS    = MAX_WAYS_DEF,
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [SIB_W-1:0]  i_set_index_bits,
    input  logic [WAYS_W-1:0] i_ways_in_use,
    input  logic [OFS_W-1:0]  i_offset_bits,
    input  logic [ADDR_W-1:0] i_address,
    output logic [CNT_W-1:0]  o_hit_count,
    output logic [CNT_W-1:0]  o_miss_count,
    output logic [CNT_W-1:0]  o_eviction_count,
    output logic [CNT_W-1:0]  o_queued_count,
    output logic [CNT_W-1:0]  o_drain_count
);

    localparam int LINE_COUNT = MAX_SETS * MAX_WAYS;
    localparam int LA_W       = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int SET_W      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W     = $clog2(MAX_WAYS + 1);
    localparam int QBLK       = QUEUE_SLOTS / 2;
    localparam int QI_W       = $clog2(QBLK);
    localparam int QB_W       = $clog2(QBLK + 1);
    localparam int QS_W       = $clog2(QUEUE_SLOTS + 1);
    localparam int MC_W       = QS_W;
    localparam int ENTRY_W    = 1 + ADDR_W + STAMP_W;
    localparam int TAB_N      = 2 ** SETRAW_W;

    // Block addresses and the current lookup.
    logic [ADDR_W-1:0]  r_acc_blk;
    logic [ADDR_W-1:0]  r_lk_blk;
    logic [MC_W-1:0]    r_mc;
    logic [LA_W-1:0]    r_clr;
    logic [WAY_W-1:0]   r_way;
    logic               r_hit_found;
    logic [WAY_W-1:0]   r_hit_way;
    logic               r_inv_found;
    logic [WAY_W-1:0]   r_inv_way;
    logic [WAY_W-1:0]   r_lru_way;
    logic [STAMP_W-1:0] r_lru_stamp;
    logic [STAMP_W-1:0] r_clock;
    logic [CNT_W-1:0]   r_hits, r_misses, r_evicts, r_queued, r_drains;

    // Miss queue.
    logic [ADDR_W-1:0]  r_qaddr [QBLK];
    logic [MC_W-1:0]    r_qmc   [QBLK];
    logic [QB_W-1:0]    r_qblocks;
    logic [QS_W-1:0]    r_qslots;
    logic [QB_W-1:0]    r_q;

    logic [WCNT_W-1:0]   w_nways;
    logic [SETRAW_W-1:0] w_mask;
    logic [SETRAW_W-1:0] w_set_raw;
    logic [SET_W-1:0]    w_set_tab [TAB_N];
    logic [SET_W-1:0]    w_set;
    logic [ADDR_W-1:0]   w_tag;
    logic [WAY_W-1:0]    w_way_sel;
    logic [WAY_W-1:0]    w_way_addr;
    logic [LA_W-1:0]     w_line;
    logic [MC_W-1:0]     w_m_eff;
    logic [STAMP_W-1:0]  w_new_stamp;
    logic                ram_we;
    logic [LA_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                rd_valid;
    logic [ADDR_W-1:0]   rd_tag;
    logic [STAMP_W-1:0]  rd_stamp;
    logic [QI_W-1:0]     w_qi;
    logic [QI_W-1:0]     w_qnew;
    logic                w_q_in_range;

    // Number of ways actually searched.
    always_comb begin
        if (i_ways_in_use == '0) begin
            w_nways = WCNT_W'(1);
        end else if (int'(i_ways_in_use) > MAX_WAYS) begin
            w_nways = WCNT_W'(MAX_WAYS);
        end else begin
            w_nways = WCNT_W'(i_ways_in_use);
        end
    end

    // Set index folded into the implemented sets through a constant table.
    for (genvar gi = 0; gi < TAB_N; gi++) begin : g_set_tab
        assign w_set_tab[gi] = SET_W'(gi % MAX_SETS);
    end

    assign w_mask    = SETRAW_W'((8'd1 << i_set_index_bits) - 8'd1);
    assign w_set_raw = r_lk_blk[SETRAW_W-1:0] & w_mask;
    assign w_set     = w_set_tab[w_set_raw];
    assign w_tag     = r_lk_blk >> i_set_index_bits;

    // Line chosen on commit: the hit way, else the first empty way, else LRU.
    always_comb begin
        if (r_hit_found) begin
            w_way_sel = r_hit_way;
        end else if (r_inv_found) begin
            w_way_sel = r_inv_way;
        end else begin
            w_way_sel = r_lru_way;
        end
    end

    assign w_way_addr = i_cmd.commit ? w_way_sel : r_way;
    assign w_line     = LA_W'(LA_W'(w_set) * LA_W'(MAX_WAYS) + LA_W'(w_way_addr));

    // A replayed block counts one lookup per merged request.
    always_comb begin
        if (i_cmd.drain_mode && r_mc != '0) begin
            w_m_eff = r_mc;
        end else begin
            w_m_eff = MC_W'(1);
        end
    end

    assign w_new_stamp = r_clock + STAMP_W'(w_m_eff) - STAMP_W'(1);

    // Line store port muxing: clearing pass or commit.
    always_comb begin
        ram_we    = i_cmd.clear_step | i_cmd.commit;
        ram_waddr = i_cmd.clear_step ? r_clr : w_line;
        ram_wdata = i_cmd.clear_step ? '0 : {1'b1, w_tag, w_new_stamp};
    end

    lcmq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(LINE_COUNT)
    ) u_lines (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.probe_rd),
        .i_raddr(w_line),
        .o_rdata(ram_rdata)
    );

    assign rd_valid = ram_rdata[ENTRY_W-1];
    assign rd_tag   = ram_rdata[STAMP_W +: ADDR_W];
    assign rd_stamp = ram_rdata[STAMP_W-1:0];

    // Queue indexing and room checks.
    assign w_qi         = r_q[QI_W-1:0];
    assign w_qnew       = r_qblocks[QI_W-1:0];
    assign w_q_in_range = (r_q < r_qblocks);

    always_comb begin
        o_sts            = '0;
        o_sts.clear_last = (r_clr == LA_W'(LINE_COUNT - 1));
        o_sts.hit_now    = rd_valid && (rd_tag == w_tag);
        o_sts.probe_last = ((8'(r_way) + 8'd1) == 8'(w_nways));
        o_sts.hit_found  = r_hit_found;
        o_sts.q_at_end   = (r_q == r_qblocks);
        o_sts.q_match    = w_q_in_range && (r_qaddr[w_qi] == r_acc_blk);
        o_sts.can_merge  = (r_qslots < QS_W'(QUEUE_SLOTS));
        o_sts.can_new    = (r_qslots < QS_W'(QUEUE_SLOTS - 1)) && (r_qblocks < QB_W'(QBLK));
        o_sts.q_empty    = (r_qblocks == '0);
        o_sts.q_last     = (QB_W'(r_q + QB_W'(1)) == r_qblocks);
    end

    // Control state of the datapath: counters, scan results, queue fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_way       <= '0;
            r_hit_found <= 1'b0;
            r_inv_found <= 1'b0;
            r_clock     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_queued    <= '0;
            r_drains    <= '0;
            r_qblocks   <= '0;
            r_qslots    <= '0;
            r_q         <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + LA_W'(1);
            end
            if (i_cmd.probe_init) begin
                r_way       <= '0;
                r_hit_found <= 1'b0;
                r_inv_found <= 1'b0;
            end
            if (i_cmd.probe_cmp) begin
                r_way <= r_way + WAY_W'(1);
                if (o_sts.hit_now) begin
                    r_hit_found <= 1'b1;
                end
                if (!rd_valid && !r_inv_found) begin
                    r_inv_found <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_clock <= r_clock + STAMP_W'(w_m_eff);
                if (r_hit_found) begin
                    r_hits <= r_hits + CNT_W'(w_m_eff);
                end else begin
                    r_hits   <= r_hits + CNT_W'(w_m_eff) - CNT_W'(1);
                    r_misses <= r_misses + CNT_W'(1);
                    if (!r_inv_found) begin
                        r_evicts <= r_evicts + CNT_W'(1);
                    end
                end
            end
            if (i_cmd.drain_start) begin
                r_drains <= r_drains + CNT_W'(1);
            end
            if (i_cmd.q_zero) begin
                r_q <= '0;
            end else if (i_cmd.q_inc) begin
                r_q <= r_q + QB_W'(1);
            end
            if (i_cmd.q_merge) begin
                r_qslots <= r_qslots + QS_W'(1);
                r_queued <= r_queued + CNT_W'(1);
            end
            if (i_cmd.q_new) begin
                r_qblocks <= r_qblocks + QB_W'(1);
                r_qslots  <= r_qslots + QS_W'(2);
                r_queued  <= r_queued + CNT_W'(1);
            end
            if (i_cmd.q_clear) begin
                r_qblocks <= '0;
                r_qslots  <= '0;
            end
        end
    end

    // Payload registers: addresses, scan way records, queue entries.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_acc_blk <= i_address >> i_offset_bits;
        end
        if (i_cmd.lk_from_acc) begin
            r_lk_blk <= r_acc_blk;
            r_mc     <= MC_W'(1);
        end
        if (i_cmd.lk_from_queue) begin
            r_lk_blk <= r_qaddr[w_qi];
            r_mc     <= r_qmc[w_qi];
        end
        if (i_cmd.probe_cmp) begin
            if (o_sts.hit_now) begin
                r_hit_way <= r_way;
            end
            if (!rd_valid && !r_inv_found) begin
                r_inv_way <= r_way;
            end
            // Strict compare keeps the lowest way among equal stamps.
            if (r_way == '0 || rd_stamp < r_lru_stamp) begin
                r_lru_way   <= r_way;
                r_lru_stamp <= rd_stamp;
            end
        end
        if (i_cmd.q_merge) begin
            r_qmc[w_qi] <= r_qmc[w_qi] + MC_W'(1);
        end
        if (i_cmd.q_new) begin
            r_qaddr[w_qnew] <= r_acc_blk;
            r_qmc[w_qnew]   <= MC_W'(1);
        end
    end

    assign o_hit_count      = r_hits;
    assign o_miss_count     = r_misses;
    assign o_eviction_count = r_evicts;
    assign o_queued_count   = r_queued;
    assign o_drain_count    = r_drains;

endmodule

[hw/rtl/lru_cache_with_miss_holding_queue.sv]
`timescale 1ns / 1ps

// Set-associative LRU cache model with a miss-holding queue.
// Requests enter on start/busy: a request is taken at a clock edge where start
// is high and busy is low. i_req_type selects a single access, a modify (two
// accesses) or a queue drain; i_address is the byte address. Each request gives
// one result: the five running counters on the o_*_count ports, marked by a
// one-cycle o_valid strobe. The receiver cannot stall, so the result is simply
// presented for that cycle; the counters then hold their value until the next.
// The work per request varies: a lookup reads the line store one way at a time
// (read, then compare), a miss scans the queue at one block per cycle, and a
// drain replays each queued block with its own lookup.
// One request is worked on at a time.
// Configuration goes through the APB port at byte addresses 0, 4 and 8 and
// may be written only while busy is low.
// After reset the block first clears the line store, one entry per cycle, all
// MAX_SETS*MAX_WAYS entries (512 at the defaults), with busy high.
module lru_cache_with_miss_holding_queue import lcmq_pkg::*; #(
    parameter int MAX_SETS    = MAX_SETS_DEF,
    parameter int MAX_WAYS    = MAX_WAYS_DEF,
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [ADDR_W-1:0]  i_address,
    output logic               o_valid,
    output logic [CNT_W-1:0]   o_hit_count,
    output logic [CNT_W-1:0]   o_miss_count,
    output logic [CNT_W-1:0]   o_eviction_count,
    output logic [CNT_W-1:0]   o_queued_count,
    output logic [CNT_W-1:0]   o_drain_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [SIB_W-1:0]  r_set_index_bits;
    logic [WAYS_W-1:0] r_ways_in_use;
    logic [OFS_W-1:0]  r_offset_bits;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    assign pready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_index_bits <= SIB_W'(4);
            r_ways_in_use    <= WAYS_W'(1);
            r_offset_bits    <= OFS_W'(4);
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_SET_INDEX_BITS: r_set_index_bits <= pwdata[SIB_W-1:0];
                REG_WAYS_IN_USE:    r_ways_in_use    <= pwdata[WAYS_W-1:0];
                REG_OFFSET_BITS:    r_offset_bits    <= pwdata[OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Configuration readback.
    always_comb begin
        case (paddr[3:2])
            REG_SET_INDEX_BITS: prdata = PDATA_W'(r_set_index_bits);
            REG_WAYS_IN_USE:    prdata = PDATA_W'(r_ways_in_use);
            REG_OFFSET_BITS:    prdata = PDATA_W'(r_offset_bits);
            default:            prdata = '0;
        endcase
    end

    lcmq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_req_type(i_req_type),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .busy      (busy),
        .o_valid   (o_valid)
    );

    lcmq_dp #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .QUEUE_SLOTS(QUEUE_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_set_index_bits(r_set_index_bits),
        .i_ways_in_use   (r_ways_in_use),
        .i_offset_bits   (r_offset_bits),
        .i_address       (i_address),
        .o_hit_count     (o_hit_count),
        .o_miss_count    (o_miss_count),
        .o_eviction_count(o_eviction_count),
        .o_queued_count  (o_queued_count),
        .o_drain_count   (o_drain_count)
    );

endmodule
